>>> hw/rtl/tvsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvsp_pkg
// Types and codes shared by the tagged value stream parser and its checker.
// ----------------------------------------------------------------------------
package tvsp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TAGEXT  = 3'd1,
    PH_LENSEL  = 3'd2,
    PH_WIDE    = 3'd3,
    PH_CONTENT = 3'd4
  } phase_t;

  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_TAGEXT  = 3'd1;
  localparam logic [2:0] ROLE_LENSEL  = 3'd2;
  localparam logic [2:0] ROLE_WIDE    = 3'd3;
  localparam logic [2:0] ROLE_CONTENT = 3'd4;

  localparam logic [1:0] KIND_PRIM  = 2'd0;
  localparam logic [1:0] KIND_OPEN  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_BOOL  = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_INVALID   = 3'd1;
  localparam logic [2:0] ERR_MISMATCH  = 3'd2;
  localparam logic [2:0] ERR_UNMATCHED = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  localparam logic [2:0] LVT_WIDE_LEN = 3'b101;
  localparam logic [2:0] LVT_OPEN     = 3'b110;
  localparam logic [2:0] LVT_CLOSE    = 3'b111;
  localparam logic [2:0] LVT_TRUE     = 3'b001;
  localparam logic [3:0] TAG_EXTENDED = 4'b1111;
  localparam logic [3:0] TAG_APP_MAX  = 4'd12;
  localparam logic [7:0] TAG_BOOLEAN  = 8'd1;
  localparam logic [7:0] EXT_TAG_BAD  = 8'hFF;
  localparam logic [7:0] LEN_SEL_2    = 8'hFE;
  localparam logic [7:0] LEN_SEL_4    = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  tag_number;
    logic        is_context;
    logic [1:0]  item_kind;
    logic        bool_value;
    logic [31:0] value_length;
    logic        header_done;
    logic        item_done;
    logic [4:0]  nest_depth;
    logic [2:0]  error_code;
  } out_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/tagged_value_stream_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_value_stream_parser_unit
// Byte-wise tag/length decoder with an open-tag stack held in a synchronous RAM.
// ----------------------------------------------------------------------------
// the result of an accepted input request is registered in the output register, or in the skid when the output stalls
// throughput: one byte per cycle while in_stall is low; the stack top is read ahead from the
//   RAM with write-to-read forwarding, so back-to-back opens and closes run freely
// a two-entry output buffer (output register plus skid) keeps in_stall registered
// reset: synchronous, active low; clears parser state, depth, error and the output buffer; the stack
//   RAM is not cleared and only entries pushed since the last restart are used as the top
module tagged_value_stream_parser_unit
  import tvsp_pkg::*;
#(
  parameter int NEST_DEPTH = 16
) (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  wire      out_stall,
  output out_rsp_t out_data
);

  localparam int DW = $clog2(NEST_DEPTH + 1);
  localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  // parser state
  phase_t      ph_r, ph_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic [7:0]  ctag_r, ctag_nxt;
  logic [31:0] lacc_r, lacc_nxt;
  logic [31:0] bleft_r, bleft_nxt;
  logic [1:0]  wcnt_r, wcnt_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [2:0]  err_r, err_nxt;

  // stack ram
  logic [7:0]    stack_mem [NEST_DEPTH];
  logic [7:0]    top_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // output buffer
  out_rsp_t out_r, skid_r;
  logic     out_v_r, skid_v_r;

  logic     accept, out_take;
  out_rsp_t res;

  // effective state after an optional frame restart
  phase_t      ph_e;
  logic [7:0]  hdr_e, ctag_e;
  logic [31:0] lacc_e, bleft_e, bleft_dec;
  logic [1:0]  wcnt_e;
  logic [DW-1:0] depth_e, depth_state;
  logic [2:0]  err_e;
  logic [7:0]  b;
  logic        do_after, do_start, push;
  logic [31:0] start_len;
  logic [2:0]  lvt;
  logic        ctx;

  assign accept   = in_valid && !skid_v_r;
  assign out_take = out_v_r && !out_stall;
  assign in_stall = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    b       = in_data.data_byte;
    ph_e    = in_data.frame_start ? PH_HEADER : ph_r;
    hdr_e   = in_data.frame_start ? 8'd0 : hdr_r;
    ctag_e  = in_data.frame_start ? 8'd0 : ctag_r;
    lacc_e  = in_data.frame_start ? 32'd0 : lacc_r;
    bleft_e = in_data.frame_start ? 32'd0 : bleft_r;
    wcnt_e  = in_data.frame_start ? 2'd0 : wcnt_r;
    depth_e = in_data.frame_start ? '0 : depth_r;
    err_e   = in_data.frame_start ? ERR_NONE : err_r;

    ph_nxt    = ph_e;
    hdr_nxt   = hdr_e;
    ctag_nxt  = ctag_e;
    lacc_nxt  = lacc_e;
    bleft_nxt = bleft_e;
    wcnt_nxt  = wcnt_e;
    depth_nxt = depth_e;
    err_nxt   = err_e;

    res       = '0;
    do_after  = 1'b0;
    do_start  = 1'b0;
    push      = 1'b0;
    start_len = 32'd0;
    bleft_dec = (bleft_e != 32'd0) ? (bleft_e - 32'd1) : 32'd0;

    if (err_e == ERR_NONE) begin
      case (ph_e)
        PH_HEADER: begin
          hdr_nxt        = b;
          ctag_nxt       = {4'd0, b[7:4]};
          res.byte_role  = ROLE_HEADER;
          res.tag_number = {4'd0, b[7:4]};
          res.is_context = b[3];
          if (b[3]) begin
            if (b[7:4] == TAG_EXTENDED) ph_nxt = PH_TAGEXT;
            else do_after = 1'b1;
          end else if (b[7:4] > TAG_APP_MAX) begin
            err_nxt = ERR_INVALID;
            ph_nxt  = PH_HEADER;
          end else begin
            do_after = 1'b1;
          end
        end
        PH_TAGEXT: begin
          ctag_nxt       = b;
          res.byte_role  = ROLE_TAGEXT;
          res.tag_number = b;
          res.is_context = 1'b1;
          if (b == EXT_TAG_BAD) begin
            err_nxt = ERR_INVALID;
            ph_nxt  = PH_HEADER;
          end else begin
            do_after = 1'b1;
          end
        end
        PH_LENSEL: begin
          res.byte_role  = ROLE_LENSEL;
          res.tag_number = ctag_e;
          res.is_context = hdr_e[3];
          if (b == LEN_SEL_2 || b == LEN_SEL_4) begin
            wcnt_nxt = (b == LEN_SEL_2) ? 2'd1 : 2'd3;
            lacc_nxt = 32'd0;
            ph_nxt   = PH_WIDE;
          end else begin
            do_start  = 1'b1;
            start_len = {24'd0, b};
          end
        end
        PH_WIDE: begin
          res.byte_role  = ROLE_WIDE;
          res.tag_number = ctag_e;
          res.is_context = hdr_e[3];
          lacc_nxt       = {lacc_e[23:0], b};
          if (wcnt_e == 2'd0) begin
            do_start  = 1'b1;
            start_len = {lacc_e[23:0], b};
          end else begin
            wcnt_nxt = wcnt_e - 2'd1;
          end
        end
        default: begin
          res.byte_role    = ROLE_CONTENT;
          res.tag_number   = ctag_e;
          res.is_context   = hdr_e[3];
          res.value_length = lacc_e;
          bleft_nxt        = bleft_dec;
          if (bleft_dec == 32'd0) begin
            res.item_done = 1'b1;
            ph_nxt        = PH_HEADER;
          end
        end
      endcase
    end

    // tag number known: interpret the lvt field
    lvt = hdr_nxt[2:0];
    ctx = hdr_nxt[3];
    if (do_after) begin
      if (ctx && lvt == LVT_OPEN) begin
        res.item_kind = KIND_OPEN;
        ph_nxt        = PH_HEADER;
        if (depth_e >= DW'(NEST_DEPTH)) begin
          err_nxt = ERR_OVERFLOW;
        end else begin
          push            = 1'b1;
          depth_nxt       = depth_e + DW'(1);
          res.header_done = 1'b1;
          res.item_done   = 1'b1;
        end
      end else if (ctx && lvt == LVT_CLOSE) begin
        res.item_kind = KIND_CLOSE;
        ph_nxt        = PH_HEADER;
        if (depth_e == '0) begin
          err_nxt = ERR_UNMATCHED;
        end else if (top_r != ctag_nxt) begin
          err_nxt = ERR_MISMATCH;
        end else begin
          depth_nxt       = depth_e - DW'(1);
          res.header_done = 1'b1;
          res.item_done   = 1'b1;
        end
      end else if (!ctx && ctag_nxt == TAG_BOOLEAN) begin
        res.item_kind   = KIND_BOOL;
        res.bool_value  = (lvt == LVT_TRUE);
        res.header_done = 1'b1;
        res.item_done   = 1'b1;
        ph_nxt          = PH_HEADER;
      end else if (lvt == LVT_WIDE_LEN) begin
        ph_nxt = PH_LENSEL;
      end else begin
        do_start  = 1'b1;
        start_len = {29'd0, lvt};
      end
    end

    if (do_start) begin
      lacc_nxt         = start_len;
      res.value_length = start_len;
      res.header_done  = 1'b1;
      if (start_len == 32'd0) begin
        res.item_done = 1'b1;
        ph_nxt        = PH_HEADER;
      end else begin
        bleft_nxt = start_len;
        ph_nxt    = PH_CONTENT;
      end
    end

    res.nest_depth = 5'(depth_nxt);
    res.error_code = err_nxt;

    wr_en       = accept && push;
    wr_addr     = depth_e[AW-1:0];
    wr_data     = ctag_nxt;
    depth_state = accept ? depth_nxt : depth_r;
    // address of the entry that will be on top next cycle
    rd_addr     = AW'(depth_state - DW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_HEADER;
      hdr_r   <= 8'd0;
      ctag_r  <= 8'd0;
      lacc_r  <= 32'd0;
      bleft_r <= 32'd0;
      wcnt_r  <= 2'd0;
      depth_r <= '0;
      err_r   <= ERR_NONE;
    end else if (accept) begin
      ph_r    <= ph_nxt;
      hdr_r   <= hdr_nxt;
      ctag_r  <= ctag_nxt;
      lacc_r  <= lacc_nxt;
      bleft_r <= bleft_nxt;
      wcnt_r  <= wcnt_nxt;
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
    end
  end

  // stack ram, top read ahead into top_r with forwarding of a same-entry push
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (wr_en && wr_addr == rd_addr) top_r <= wr_data;
    else top_r <= stack_mem[rd_addr];
  end

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_v_r || out_take) out_v_r <= 1'b1;
      else skid_v_r <= 1'b1;
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) out_r <= skid_r;
    end else if (accept) begin
      if (!out_v_r || out_take) out_r <= res;
      else skid_r <= res;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tvsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvsp_checker
// Port-level checks for the tagged value stream parser, bound to the top level.
// ----------------------------------------------------------------------------
module tvsp_checker
  import tvsp_pkg::*;
(
  input wire      clk,
  input wire      rst_n,
  input wire      in_stall,
  input wire      out_valid,
  input wire      out_stall,
  input out_rsp_t out_data
);

  // held result must not move
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input only backs up once the output side holds a result
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with output empty");

  // error results never complete a header or an item
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != ERR_NONE |->
      !out_data.header_done && !out_data.item_done)
    else $error("error result flags completion");

  // opening and closing tags carry no length
  a_tag_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.header_done &&
      (out_data.item_kind == KIND_OPEN || out_data.item_kind == KIND_CLOSE) |->
      out_data.value_length == 32'd0)
    else $error("constructed tag with length");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

endmodule

bind tagged_value_stream_parser_unit tvsp_checker u_tvsp_checker (.*);
`default_nettype wire
